// ===== rtl/core/dppq_pkg.sv =====
// ----------------------------------------------------------------------------
// dppq_pkg
// Shared types and constants for the dual priority process queue.
// ----------------------------------------------------------------------------
package dppq_pkg;

	localparam int unsigned PID_W = 6;
	localparam int unsigned PRIO_W = 4;
	localparam int unsigned CNT_W = 5;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_REMOVE = 1'b1
	} req_t;

	typedef enum logic {
		SEL_READY   = 1'b0,
		SEL_BLOCKED = 1'b1
	} queue_sel_t;

	// one queue entry
	typedef struct packed {
		logic [PID_W-1:0]  handle;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// request broadcast along the row of cells
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [PID_W-1:0]  handle;
		logic [PRIO_W-1:0] prio;
	} cmd_t;

endpackage

// ===== rtl/core/dppq_cell.sv =====
// ----------------------------------------------------------------------------
// dppq_cell
// One slot of a sorted shift-register queue. Shifts towards the tail on
// insert, towards the head on remove.
// ----------------------------------------------------------------------------
module dppq_cell (
	input  logic            clk,
	input  dppq_pkg::cmd_t  cmd,
	input  logic            occupied,
	input  logic            prev_after,
	input  dppq_pkg::entry_t prev_entry,
	input  dppq_pkg::entry_t next_entry,
	input  logic            hit_in,
	output logic            after,
	output logic            hit_out,
	output dppq_pkg::entry_t entry
);

	dppq_pkg::entry_t entry_q;
	dppq_pkg::entry_t new_entry;
	logic             match;

	assign new_entry.handle = cmd.handle;
	assign new_entry.prio   = cmd.prio;

	// new item lands behind every entry of equal or higher priority
	assign after   = occupied && (entry_q.prio >= cmd.prio);
	assign match   = occupied && (entry_q.handle == cmd.handle);
	assign hit_out = hit_in || match;
	assign entry   = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.ins && !after) begin
			entry_q <= prev_after ? new_entry : prev_entry;
		end else if (cmd.rem && hit_out) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ===== rtl/core/dppq_queue.sv =====
// ----------------------------------------------------------------------------
// dppq_queue
// Row of cells forming one priority-sorted queue, plus its fill counter.
// ----------------------------------------------------------------------------
module dppq_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dppq_pkg::cmd_t               cmd,
	output logic                         full,
	output logic                         found,
	output logic [dppq_pkg::PID_W-1:0]   head,
	output logic [$clog2(DEPTH+1)-1:0]   fill
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0]     fill_q;
	dppq_pkg::cmd_t    cell_cmd;
	dppq_pkg::entry_t  ent [DEPTH];
	dppq_pkg::entry_t  new_entry;
	logic [DEPTH-1:0]  after;
	logic [DEPTH:0]    hit;
	logic              ins_en;

	assign full      = (fill_q == CW'(DEPTH));
	assign found     = hit[DEPTH];
	assign ins_en    = cmd.ins && !full;
	assign fill      = fill_q;
	assign head      = (fill_q != '0) ? ent[0].handle : '0;
	assign hit[0]    = 1'b0;
	assign new_entry = '{handle: cmd.handle, prio: cmd.prio};

	always_comb begin
		cell_cmd     = cmd;
		cell_cmd.ins = ins_en;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic             occ;
		logic             p_after;
		dppq_pkg::entry_t p_ent;
		dppq_pkg::entry_t n_ent;

		assign occ = (fill_q > CW'(i));
		if (i == 0) begin : g_first
			assign p_after = 1'b1;
			assign p_ent   = new_entry;
		end else begin : g_mid
			assign p_after = after[i-1];
			assign p_ent   = ent[i-1];
		end
		// tail slot leaves the queue on remove, so what it takes is irrelevant
		if (i == DEPTH - 1) begin : g_last
			assign n_ent = ent[i];
		end else begin : g_inner
			assign n_ent = ent[i+1];
		end

		dppq_cell u_cell (
			.clk        (clk),
			.cmd        (cell_cmd),
			.occupied   (occ),
			.prev_after (p_after),
			.prev_entry (p_ent),
			.next_entry (n_ent),
			.hit_in     (hit[i]),
			.after      (after[i]),
			.hit_out    (hit[i+1]),
			.entry      (ent[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ins_en) begin
			fill_q <= fill_q + CW'(1);
		end else if (cmd.rem && found) begin
			fill_q <= fill_q - CW'(1);
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins && full) |=> $stable(fill_q) && $stable(head))
		else $error("insert into full queue changed it");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ins_en |=> fill_q == $past(fill_q) + CW'(1))
		else $error("insert did not grow queue");

	a_miss_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rem && !found) |=> $stable(fill_q) && $stable(head))
		else $error("remove of absent handle changed queue");

endmodule

// ===== rtl/core/dual_priority_process_queue_unit.sv =====
// ----------------------------------------------------------------------------
// dual_priority_process_queue_unit
// Ready and blocked process queues, each kept sorted by priority.
// ----------------------------------------------------------------------------
// Each input item inserts a handle with a priority into, or removes a handle
// from, the ready or blocked queue chosen by queue_sel. Inserts go behind all
// entries of equal or higher priority; removes take the first match from the
// head. Every item gives one result item: a status plus head handle and count
// of both queues after the item.
// Each queue is a row of QUEUE_DEPTH cells that all compare against the
// request at once and shift one place in the same cycle, so an item is
// accepted every cycle while in_ready is high and its result is valid in the next cycle.
// The result sits in an output register; in_ready is high while that register
// is empty or being taken, so a stalled receiver holds back input and leaves
// both queues untouched.
// Reset empties both queues (fill counts to zero) and clears out_valid; no
// clearing pass is needed, slot contents are only read below the fill count.
// ----------------------------------------------------------------------------
module dual_priority_process_queue_unit #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic                           queue_sel,
	input  logic [dppq_pkg::PID_W-1:0]     process_id,
	input  logic [dppq_pkg::PRIO_W-1:0]    priority_req,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [dppq_pkg::STATUS_W-1:0]  status,
	output logic [dppq_pkg::PID_W-1:0]     ready_head_id,
	output logic [dppq_pkg::CNT_W-1:0]     ready_count,
	output logic [dppq_pkg::PID_W-1:0]     blocked_head_id,
	output logic [dppq_pkg::CNT_W-1:0]     blocked_count
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic               accept;
	logic               is_ins;
	logic               is_rem;
	dppq_pkg::cmd_t     rdy_cmd;
	dppq_pkg::cmd_t     blk_cmd;
	logic               rdy_full, rdy_found;
	logic               blk_full, blk_found;
	logic [CW-1:0]      rdy_fill, blk_fill;
	logic               sel_full, sel_found;
	dppq_pkg::status_t  status_d;
	dppq_pkg::status_t  status_q;
	logic               out_valid_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_ins   = accept && (dppq_pkg::req_t'(req_type) == dppq_pkg::REQ_INSERT);
	assign is_rem   = accept && (dppq_pkg::req_t'(req_type) == dppq_pkg::REQ_REMOVE);

	always_comb begin
		rdy_cmd.handle = process_id;
		rdy_cmd.prio   = priority_req;
		rdy_cmd.ins    = 1'b0;
		rdy_cmd.rem    = 1'b0;
		blk_cmd        = rdy_cmd;
		case (dppq_pkg::queue_sel_t'(queue_sel))
			dppq_pkg::SEL_READY: begin
				rdy_cmd.ins = is_ins;
				rdy_cmd.rem = is_rem;
			end
			dppq_pkg::SEL_BLOCKED: begin
				blk_cmd.ins = is_ins;
				blk_cmd.rem = is_rem;
			end
			default: begin
			end
		endcase
	end

	dppq_queue #(.DEPTH(QUEUE_DEPTH)) u_ready (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rdy_cmd),
		.full   (rdy_full),
		.found  (rdy_found),
		.head   (ready_head_id),
		.fill   (rdy_fill)
	);

	dppq_queue #(.DEPTH(QUEUE_DEPTH)) u_blocked (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (blk_cmd),
		.full   (blk_full),
		.found  (blk_found),
		.head   (blocked_head_id),
		.fill   (blk_fill)
	);

	assign sel_full  = queue_sel ? blk_full : rdy_full;
	assign sel_found = queue_sel ? blk_found : rdy_found;

	always_comb begin
		case (dppq_pkg::req_t'(req_type))
			dppq_pkg::REQ_INSERT: status_d = sel_full ? dppq_pkg::ST_FULL : dppq_pkg::ST_DONE;
			dppq_pkg::REQ_REMOVE: status_d = sel_found ? dppq_pkg::ST_DONE : dppq_pkg::ST_MISSING;
			default:              status_d = dppq_pkg::ST_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	// queues only move on an accepted item, so heads and counts stay paired
	// with the held status while the receiver stalls
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign ready_count   = dppq_pkg::CNT_W'(rdy_fill);
	assign blocked_count = dppq_pkg::CNT_W'(blk_fill);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(ready_count) && $stable(blocked_count)
			&& $stable(status_q))
		else $error("result changed while stalled");

	a_one_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({rdy_cmd.ins, rdy_cmd.rem, blk_cmd.ins, blk_cmd.rem}))
		else $error("more than one queue operation at once");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item gave no result");

endmodule

// ===== bench/tb_dual_priority_process_queue_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_priority_process_queue_unit
// Self-checking bench for the ready/blocked sorted process queues.
// ----------------------------------------------------------------------------
// A directed opening covers empty removes, priority extremes, stable order
// among equal priorities, duplicate handles and a missing handle. Random
// bursts then favour one queue and lean towards insert or remove so that
// both queues run from empty to full and back. A scoreboard keeps its own
// copy of both queues and checks every result item field by field.
// ----------------------------------------------------------------------------
module tb_dual_priority_process_queue_unit;

	localparam int unsigned DEPTH        = 16;
	localparam int unsigned PHASE_ITEMS  = 212;
	localparam int unsigned BURST_ITEMS  = 48;
	localparam int unsigned HOLD_CYCLES  = 40;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	typedef struct {
		dppq_pkg::status_t                 status;
		logic [dppq_pkg::PID_W-1:0]        ready_head;
		logic [dppq_pkg::CNT_W-1:0]        ready_cnt;
		logic [dppq_pkg::PID_W-1:0]        blocked_head;
		logic [dppq_pkg::CNT_W-1:0]        blocked_cnt;
	} queue_snapshot_t;

	// mirror of both queues plus the results still owed by the block
	class queue_scoreboard;
		dppq_pkg::entry_t ready_q[$];
		dppq_pkg::entry_t blocked_q[$];
		queue_snapshot_t  owed_q[$];
		int unsigned      failures;

		function int unsigned pending();
			return owed_q.size();
		endfunction

		function void note_request(dppq_pkg::req_t rq, dppq_pkg::queue_sel_t qs,
				logic [dppq_pkg::PID_W-1:0] pid, logic [dppq_pkg::PRIO_W-1:0] pr);
			dppq_pkg::entry_t work[$];
			dppq_pkg::entry_t ent;
			queue_snapshot_t  snap;
			int               pos;
			if (qs == dppq_pkg::SEL_BLOCKED) begin
				work = blocked_q;
			end else begin
				work = ready_q;
			end
			snap.status = dppq_pkg::ST_DONE;
			pos = 0;
			if (rq == dppq_pkg::REQ_INSERT) begin
				if (work.size() >= DEPTH) begin
					snap.status = dppq_pkg::ST_FULL;
				end else begin
					// behind every entry of equal or higher priority
					while (pos < work.size() && work[pos].prio >= pr)
						pos++;
					ent.handle = pid;
					ent.prio = pr;
					work.insert(pos, ent);
				end
			end else begin
				while (pos < work.size() && work[pos].handle != pid)
					pos++;
				if (pos >= work.size()) begin
					snap.status = dppq_pkg::ST_MISSING;
				end else begin
					work.delete(pos);
				end
			end
			if (qs == dppq_pkg::SEL_BLOCKED) begin
				blocked_q = work;
			end else begin
				ready_q = work;
			end
			snap.ready_head   = (ready_q.size() == 0) ? '0 : ready_q[0].handle;
			snap.ready_cnt    = dppq_pkg::CNT_W'(ready_q.size());
			snap.blocked_head = (blocked_q.size() == 0) ? '0 : blocked_q[0].handle;
			snap.blocked_cnt  = dppq_pkg::CNT_W'(blocked_q.size());
			owed_q.push_back(snap);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				failures++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want,
					got);
			end
		endfunction

		function void check_result(logic [dppq_pkg::STATUS_W-1:0] st,
				logic [dppq_pkg::PID_W-1:0] rh, logic [dppq_pkg::CNT_W-1:0] rc,
				logic [dppq_pkg::PID_W-1:0] bh, logic [dppq_pkg::CNT_W-1:0] bc);
			queue_snapshot_t want;
			if (owed_q.size() == 0) begin
				failures++;
				$display("%0t: unexpected result item, expected none, actual status %0d",
					$time, st);
				return;
			end
			want = owed_q.pop_front();
			compare_field("status", 8'(want.status), 8'(st));
			compare_field("ready_head_id", 8'(want.ready_head), 8'(rh));
			compare_field("ready_count", 8'(want.ready_cnt), 8'(rc));
			compare_field("blocked_head_id", 8'(want.blocked_head), 8'(bh));
			compare_field("blocked_count", 8'(want.blocked_cnt), 8'(bc));
		endfunction
	endclass

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic                                req_type = 1'b0;
	logic                                queue_sel = 1'b0;
	logic [dppq_pkg::PID_W-1:0]          process_id = '0;
	logic [dppq_pkg::PRIO_W-1:0]         priority_req = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic [dppq_pkg::STATUS_W-1:0]       status;
	logic [dppq_pkg::PID_W-1:0]          ready_head_id;
	logic [dppq_pkg::CNT_W-1:0]          ready_count;
	logic [dppq_pkg::PID_W-1:0]          blocked_head_id;
	logic [dppq_pkg::CNT_W-1:0]          blocked_count;

	queue_scoreboard sb = new();
	int unsigned     tx_idle_pct = 0;
	int unsigned     rx_idle_pct = 0;
	int unsigned     hold_requests = 0;
	int unsigned     hold_served = 0;
	int unsigned     hold_left = 0;
	int unsigned     cycle_count = 0;

	dual_priority_process_queue_unit #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.queue_sel       (queue_sel),
		.process_id      (process_id),
		.priority_req    (priority_req),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.ready_head_id   (ready_head_id),
		.ready_count     (ready_count),
		.blocked_head_id (blocked_head_id),
		.blocked_count   (blocked_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("dual_priority_process_queue_unit test failed");
			$finish;
		end
	end

	// receiver: checks each taken result, then picks ready for the next edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(status, ready_head_id, ready_count, blocked_head_id,
				blocked_count);
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// leaves valid high on return; the next call or a drain decides what follows
	task automatic send_request(input dppq_pkg::req_t rq, input dppq_pkg::queue_sel_t qs,
			input logic [dppq_pkg::PID_W-1:0] pid, input logic [dppq_pkg::PRIO_W-1:0] pr);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= rq;
		queue_sel    <= qs;
		process_id   <= pid;
		priority_req <= pr;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(rq, qs, pid, pr);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// remove mostly targets a handle that is present; narrow value sets breed
	// duplicates and equal priorities
	task automatic random_request(input int unsigned insert_pct,
			input dppq_pkg::queue_sel_t fav);
		dppq_pkg::queue_sel_t        qs;
		dppq_pkg::req_t              rq;
		logic [dppq_pkg::PID_W-1:0]  pid;
		logic [dppq_pkg::PRIO_W-1:0] pr;
		dppq_pkg::entry_t            pool[$];
		qs = ($urandom_range(0, 99) < 75) ? fav : dppq_pkg::queue_sel_t'(~fav);
		rq = ($urandom_range(0, 99) < insert_pct) ? dppq_pkg::REQ_INSERT
			: dppq_pkg::REQ_REMOVE;
		pid = ($urandom_range(0, 4) == 0) ? dppq_pkg::PID_W'($urandom_range(0, 3))
			: dppq_pkg::PID_W'($urandom_range(0, 63));
		pr = ($urandom_range(0, 3) == 0) ? dppq_pkg::PRIO_W'($urandom_range(0, 2) * 7)
			: dppq_pkg::PRIO_W'($urandom_range(0, 15));
		if (rq == dppq_pkg::REQ_REMOVE) begin
			if (qs == dppq_pkg::SEL_BLOCKED) begin
				pool = sb.blocked_q;
			end else begin
				pool = sb.ready_q;
			end
			if (pool.size() != 0 && $urandom_range(0, 99) < 85)
				pid = pool[$urandom_range(0, pool.size() - 1)].handle;
		end
		send_request(rq, qs, pid, pr);
	endtask

	initial begin
		int unsigned          insert_pct;
		dppq_pkg::queue_sel_t fav;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening
		send_request(dppq_pkg::REQ_REMOVE, dppq_pkg::SEL_READY, 6'd0, 4'd0);
		send_request(dppq_pkg::REQ_REMOVE, dppq_pkg::SEL_BLOCKED, 6'd63, 4'd15);
		send_request(dppq_pkg::REQ_INSERT, dppq_pkg::SEL_READY, 6'd0, 4'd0);
		send_request(dppq_pkg::REQ_INSERT, dppq_pkg::SEL_READY, 6'd63, 4'd15);
		send_request(dppq_pkg::REQ_INSERT, dppq_pkg::SEL_READY, 6'd5, 4'd7);
		send_request(dppq_pkg::REQ_INSERT, dppq_pkg::SEL_READY, 6'd6, 4'd7);
		send_request(dppq_pkg::REQ_INSERT, dppq_pkg::SEL_READY, 6'd5, 4'd9);
		send_request(dppq_pkg::REQ_REMOVE, dppq_pkg::SEL_READY, 6'd63, 4'd0);
		send_request(dppq_pkg::REQ_REMOVE, dppq_pkg::SEL_READY, 6'd5, 4'd15);
		send_request(dppq_pkg::REQ_REMOVE, dppq_pkg::SEL_READY, 6'd5, 4'd0);
		send_request(dppq_pkg::REQ_REMOVE, dppq_pkg::SEL_READY, 6'd42, 4'd0);
		send_request(dppq_pkg::REQ_INSERT, dppq_pkg::SEL_BLOCKED, 6'd63, 4'd15);
		send_request(dppq_pkg::REQ_INSERT, dppq_pkg::SEL_BLOCKED, 6'd0, 4'd0);
		send_request(dppq_pkg::REQ_REMOVE, dppq_pkg::SEL_BLOCKED, 6'd0, 4'd0);
		drain_results();

		insert_pct = 90;
		fav = dppq_pkg::SEL_READY;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 28;
					rx_idle_pct = 85;
				end
				1: begin
					tx_idle_pct = 85;
					rx_idle_pct = 28;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					// long receiver stall while items keep coming
					hold_requests++;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % BURST_ITEMS == 0) begin
					if (n == 0) begin
						insert_pct = 90;
					end else begin
						case ($urandom_range(0, 2))
							0: insert_pct = 90;
							1: insert_pct = 50;
							default: insert_pct = 20;
						endcase
					end
					fav = dppq_pkg::queue_sel_t'($urandom_range(0, 1));
				end
				random_request(insert_pct, fav);
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("dual_priority_process_queue_unit test passed");
		end else begin
			$display("dual_priority_process_queue_unit test failed");
		end
		$finish;
	end

endmodule
